>>> src/fvn_pkg.sv
package fvn_pkg;

    // lattice hash multipliers and per-octave seed step
    localparam logic [31:0] HASH_MX   = 32'd374761393;
    localparam logic [31:0] HASH_MY   = 32'd668265263;
    localparam logic [31:0] HASH_MS   = 32'd2246822519;
    localparam logic [31:0] HASH_MIX  = 32'd1274126177;
    localparam logic [31:0] SEED_STEP = 32'd1013;

    // datapath steps within one octave
    typedef enum logic [2:0] {
        PH_MUL,
        PH_MIX,
        PH_HMUL,
        PH_CV,
        PH_B1,
        PH_B2,
        PH_B3,
        PH_B4
    } phase_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   run;
        phase_t phase;
        logic   div_init;
        logic   div_step;
        logic   out_load;
    } fvn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic zero;
        logic oct_last;
    } fvn_status_t;

endpackage

>>> src/fvn_datapath.sv
module fvn_datapath
    import fvn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic                      aclk,
    input  fvn_cmd_t                  cmd,
    output fvn_status_t               status,
    input  logic signed [31:0]        x_coord,
    input  logic signed [31:0]        y_coord,
    input  logic        [31:0]        seed,
    input  logic        [3:0]         octave_count,
    output logic        [FRAC_BITS:0] noise_value
);

    localparam int F      = FRAC_BITS;
    localparam int CW     = 32 + F;
    localparam int OW     = $clog2(MAX_OCTAVES + 1);
    localparam int VW     = F + 1;
    localparam int PW     = 2 * F + 4;
    localparam int ACC_W  = F + MAX_OCTAVES;
    localparam int NUM_W  = ACC_W + 1;
    localparam int DEN_W  = MAX_OCTAVES;
    localparam int NW     = 32 + F + 2;
    localparam logic [VW-1:0] ONE_V  = VW'(1) << F;
    localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);
    localparam logic [NW-1:0] DIV_D  = NW'(33'h0FFFFFFFF);

    // corner value: round(h * 2^F / (2^32 - 1)) by reciprocal estimate and correction
    function automatic logic [VW-1:0] corner_value(input logic [31:0] h);
        logic [NW-1:0] num;
        logic [NW-1:0] est;
        logic [NW-1:0] q;
        logic [NW-1:0] r;
        num = (NW'(h) << F) + NW'(32'h7FFFFFFF);
        est = num + (num >> 32);
        q   = est >> 32;
        r   = num - (q << 32) + q;
        if (r >= DIV_D) begin
            q = q + NW'(1);
            r = r - DIV_D;
        end
        if (r >= DIV_D) begin
            q = q + NW'(1);
        end
        return q[VW-1:0];
    endfunction

    logic [CW-1:0]    xs_reg, xs_next, ys_reg, ys_next;
    logic [31:0]      s_reg, s_next;
    logic [OW-1:0]    n_reg, n_next, oct_reg, oct_next;
    logic [31:0]      pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    logic [2*F-1:0]   ttx_reg, ttx_next, tty_reg, tty_next;
    logic [31:0]      g_reg [4];
    logic [31:0]      g_next [4];
    logic [31:0]      hm_reg [4];
    logic [31:0]      hm_next [4];
    logic [VW-1:0]    t2x_reg, t2x_next, t2y_reg, t2y_next;
    logic [F+1:0]     wx_reg, wx_next, wy_reg, wy_next;
    logic [PW-1:0]    spx_reg, spx_next, spy_reg, spy_next;
    logic [VW-1:0]    cv_reg [4];
    logic [VW-1:0]    cv_next [4];
    logic [VW-1:0]    sx_reg, sx_next, sy_reg, sy_next;
    logic [PW-1:0]    p_reg [4];
    logic [PW-1:0]    p_next [4];
    logic [VW-1:0]    r0_reg, r0_next, r1_reg, r1_next;
    logic [PW-1:0]    qa_reg, qa_next, qb_reg, qb_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [VW-1:0]    qsh_reg, qsh_next;
    logic [VW-1:0]    noise_reg, noise_next;

    logic [31:0]      cx, cy, base;
    logic [31:0]      h [4];
    logic [31:0]      hf;
    logic [F-1:0]     fx, fy;
    logic [4:0]       cnt_ext;
    logic [DEN_W-1:0] denom;
    logic [NUM_W-1:0] num;
    logic [DEN_W:0]   rem2;
    logic             ge;
    logic [PW-1:0]    blend_sum;
    logic [VW-1:0]    oct_val;

    assign cx    = xs_reg[F+31:F];
    assign cy    = ys_reg[F+31:F];
    assign fx    = xs_reg[F-1:0];
    assign fy    = ys_reg[F-1:0];
    assign denom = DEN_W'(((DEN_W + 1)'(1) << n_reg) - (DEN_W + 1)'(1));
    assign num   = NUM_W'(acc_reg) + NUM_W'(denom >> 1);
    assign rem2  = {rem_reg, qsh_reg[VW-1]};
    assign ge    = rem2 >= {1'b0, denom};

    assign status.zero     = (n_reg == '0);
    assign status.oct_last = (oct_reg == n_reg - OW'(1));
    assign noise_value     = noise_reg;

    // next-state logic of all datapath registers
    always_comb begin
        xs_next = xs_reg;   ys_next = ys_reg;   s_next = s_reg;
        n_next = n_reg;     oct_next = oct_reg;
        pa_next = pa_reg;   pb_next = pb_reg;   pc_next = pc_reg;
        ttx_next = ttx_reg; tty_next = tty_reg;
        t2x_next = t2x_reg; t2y_next = t2y_reg;
        wx_next = wx_reg;   wy_next = wy_reg;
        spx_next = spx_reg; spy_next = spy_reg;
        sx_next = sx_reg;   sy_next = sy_reg;
        r0_next = r0_reg;   r1_next = r1_reg;
        qa_next = qa_reg;   qb_next = qb_reg;
        acc_next = acc_reg; rem_next = rem_reg; qsh_next = qsh_reg;
        noise_next = noise_reg;
        g_next = g_reg;     hm_next = hm_reg;
        cv_next = cv_reg;   p_next = p_reg;
        cnt_ext = {1'b0, octave_count};
        base = pa_reg + pb_reg + pc_reg;
        h[0] = base;
        h[1] = base + HASH_MX;
        h[2] = base + HASH_MY;
        h[3] = base + HASH_MX + HASH_MY;
        hf = '0;
        blend_sum = qa_reg + qb_reg + HALF_P;
        oct_val = blend_sum[F+VW-1:F];

        if (cmd.load) begin
            xs_next  = {{F{x_coord[31]}}, x_coord};
            ys_next  = {{F{y_coord[31]}}, y_coord};
            s_next   = seed;
            n_next   = (cnt_ext > 5'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES) : OW'(cnt_ext);
            oct_next = '0;
            acc_next = '0;
        end

        if (cmd.run) begin
            unique case (cmd.phase)
                PH_MUL: begin
                    pa_next  = cx * HASH_MX;
                    pb_next  = cy * HASH_MY;
                    pc_next  = s_reg * HASH_MS;
                    ttx_next = (2 * F)'(fx) * (2 * F)'(fx);
                    tty_next = (2 * F)'(fy) * (2 * F)'(fy);
                end
                PH_MIX: begin
                    for (int k = 0; k < 4; k++) begin
                        g_next[k] = h[k] ^ (h[k] >> 13);
                    end
                    t2x_next = VW'((PW'(ttx_reg) + HALF_P) >> F);
                    t2y_next = VW'((PW'(tty_reg) + HALF_P) >> F);
                    wx_next  = (F + 2)'(3) * (F + 2)'(ONE_V) - ((F + 2)'(fx) << 1);
                    wy_next  = (F + 2)'(3) * (F + 2)'(ONE_V) - ((F + 2)'(fy) << 1);
                end
                PH_HMUL: begin
                    for (int k = 0; k < 4; k++) begin
                        hm_next[k] = g_reg[k] * HASH_MIX;
                    end
                    spx_next = PW'(t2x_reg) * PW'(wx_reg);
                    spy_next = PW'(t2y_reg) * PW'(wy_reg);
                end
                PH_CV: begin
                    for (int k = 0; k < 4; k++) begin
                        hf = hm_reg[k] ^ (hm_reg[k] >> 16);
                        cv_next[k] = corner_value(hf);
                    end
                    sx_next = VW'((spx_reg + HALF_P) >> F);
                    sy_next = VW'((spy_reg + HALF_P) >> F);
                end
                PH_B1: begin
                    p_next[0] = PW'(cv_reg[0]) * PW'(ONE_V - sx_reg);
                    p_next[1] = PW'(cv_reg[1]) * PW'(sx_reg);
                    p_next[2] = PW'(cv_reg[2]) * PW'(ONE_V - sx_reg);
                    p_next[3] = PW'(cv_reg[3]) * PW'(sx_reg);
                end
                PH_B2: begin
                    r0_next = VW'((p_reg[0] + p_reg[1] + HALF_P) >> F);
                    r1_next = VW'((p_reg[2] + p_reg[3] + HALF_P) >> F);
                end
                PH_B3: begin
                    qa_next = PW'(r0_reg) * PW'(ONE_V - sy_reg);
                    qb_next = PW'(r1_reg) * PW'(sy_reg);
                end
                PH_B4: begin
                    // horner form of the amplitude-weighted sum
                    acc_next = (acc_reg << 1) + ACC_W'(oct_val);
                    xs_next  = xs_reg << 1;
                    ys_next  = ys_reg << 1;
                    s_next   = s_reg + SEED_STEP;
                    oct_next = oct_reg + OW'(1);
                end
                default: begin
                end
            endcase
        end

        // restoring divide by 2^n - 1, one quotient bit a cycle
        if (cmd.div_init) begin
            rem_next = num[NUM_W-1:VW];
            qsh_next = num[VW-1:0];
        end
        if (cmd.div_step) begin
            rem_next = ge ? DEN_W'(rem2 - {1'b0, denom}) : DEN_W'(rem2);
            qsh_next = {qsh_reg[VW-2:0], ge};
        end

        if (cmd.out_load) begin
            if (status.zero) begin
                noise_next = '0;
            end else begin
                noise_next = (qsh_reg > ONE_V) ? ONE_V : qsh_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        xs_reg <= xs_next;   ys_reg <= ys_next;   s_reg <= s_next;
        n_reg <= n_next;     oct_reg <= oct_next;
        pa_reg <= pa_next;   pb_reg <= pb_next;   pc_reg <= pc_next;
        ttx_reg <= ttx_next; tty_reg <= tty_next;
        t2x_reg <= t2x_next; t2y_reg <= t2y_next;
        wx_reg <= wx_next;   wy_reg <= wy_next;
        spx_reg <= spx_next; spy_reg <= spy_next;
        sx_reg <= sx_next;   sy_reg <= sy_next;
        r0_reg <= r0_next;   r1_reg <= r1_next;
        qa_reg <= qa_next;   qb_reg <= qb_next;
        acc_reg <= acc_next; rem_reg <= rem_next; qsh_reg <= qsh_next;
        noise_reg <= noise_next;
        g_reg <= g_next;     hm_reg <= hm_next;
        cv_reg <= cv_next;   p_reg <= p_next;
    end

endmodule

>>> src/fvn_ctrl.sv
module fvn_ctrl
    import fvn_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  fvn_status_t status,
    output fvn_cmd_t    cmd
);

    localparam int DCW = $clog2(FRAC_BITS + 2);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_OCT,
        S_DINIT,
        S_DIV,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic           m_valid_reg, m_valid_next;
    logic           out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // sequencing of octave steps, divide and result hand-off
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        dcnt_next    = dcnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.phase    = phase_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                phase_next = PH_MUL;
                state_next = status.zero ? S_DONE : S_OCT;
            end
            S_OCT: begin
                cmd.run = 1'b1;
                if (phase_reg == PH_B4) begin
                    phase_next = PH_MUL;
                    if (status.oct_last) begin
                        state_next = S_DINIT;
                    end
                end else begin
                    phase_next = phase_t'(phase_reg + 3'd1);
                end
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + DCW'(1);
                if (dcnt_reg == DIV_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_MUL;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            dcnt_reg    <= dcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> src/fractal_value_noise_2d_core.sv
// channel   | ports                                            | direction
// request   | s_valid s_ready s_x_coord s_y_coord s_seed        | in
//           | s_octave_count                                   |
// result    | m_valid m_ready m_noise_value                    | out
//
// A request with n octaves (n >= 1) runs the eight-step octave sequence of the shared
// hash/blend datapath once per octave and then the bit-serial divide; a zero-octave
// request skips both. The result is then handed off through the output register.
// aresetn is synchronous and clears only the controller and result valid.
// A finished result waits in the output register while the next request is taken in;
// a new result waits in the quotient register in turn until the old one has been taken.
module fractal_value_noise_2d_core
    import fvn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [31:0]        s_x_coord,
    input  logic signed [31:0]        s_y_coord,
    input  logic        [31:0]        s_seed,
    input  logic        [3:0]         s_octave_count,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic        [FRAC_BITS:0] m_noise_value
);

    fvn_cmd_t    cmd;
    fvn_status_t status;

    // sequencer
    fvn_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // noise datapath
    fvn_datapath #(
        .MAX_OCTAVES(MAX_OCTAVES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .cmd          (cmd),
        .status       (status),
        .x_coord      (s_x_coord),
        .y_coord      (s_y_coord),
        .seed         (s_seed),
        .octave_count (s_octave_count),
        .noise_value  (m_noise_value)
    );

endmodule

>>> tb/sv/fvn_checker.sv
module fvn_checker
    import fvn_pkg::*;
#(
    parameter int MAX_OCT = 8,
    parameter int FB      = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_x_coord,
    input  logic signed [31:0] s_y_coord,
    input  logic [31:0]        s_seed,
    input  logic [3:0]         s_octave_count,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [FB:0]        m_noise_value,
    output int                 fail_count,
    output int                 pending_count
);

    localparam logic [63:0] ONE  = 64'd1 << FB;
    localparam logic [63:0] HALF = 64'd1 << (FB - 1);

    logic [FB:0] noise_queue[$];
    int          mismatches = 0;

    // lattice corner hash scaled to q1.F
    function automatic logic [63:0] corner_level(logic [31:0] cx, logic [31:0] cy,
                                                 logic [31:0] s);
        logic [31:0] h;
        logic [63:0] w;
        h = cx * HASH_MX + cy * HASH_MY + s * HASH_MS;
        h = (h ^ (h >> 13)) * HASH_MIX;
        h = h ^ (h >> 16);
        w = {32'd0, h};
        return ((w << FB) + 64'h7FFF_FFFF) / 64'hFFFF_FFFF;
    endfunction

    function automatic logic [63:0] ease(logic [63:0] t);
        logic [63:0] t2;
        t2 = (t * t + HALF) >> FB;
        return (t2 * (3 * ONE - 2 * t) + HALF) >> FB;
    endfunction

    function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] s);
        return (a * (ONE - s) + b * s + HALF) >> FB;
    endfunction

    // normalized fbm sum over the requested octaves
    function automatic logic [FB:0] fbm_noise(logic signed [31:0] x, logic signed [31:0] y,
                                              logic [31:0] seed, logic [3:0] cnt);
        logic [63:0] xe, ye, xs, ys, fx, fy, sx, sy, acc, den, r, v;
        logic [31:0] cx, cy, s;
        int n;
        n = (cnt > MAX_OCT) ? MAX_OCT : int'(cnt);
        if (n == 0) return '0;
        xe = {{32{x[31]}}, x};
        ye = {{32{y[31]}}, y};
        acc = 0;
        for (int i = 0; i < n; i++) begin
            s = seed + i * SEED_STEP;
            xs = xe << i;
            ys = ye << i;
            cx = xs[FB +: 32];
            cy = ys[FB +: 32];
            fx = xs & (ONE - 1);
            fy = ys & (ONE - 1);
            sx = ease(fx);
            sy = ease(fy);
            v = mix(mix(corner_level(cx, cy, s), corner_level(cx + 1, cy, s), sx),
                    mix(corner_level(cx, cy + 1, s), corner_level(cx + 1, cy + 1, s), sx),
                    sy);
            acc += v << (n - 1 - i);
        end
        den = (64'd1 << n) - 1;
        r = (acc + (den >> 1)) / den;
        if (r > ONE) r = ONE;
        return r[FB:0];
    endfunction

    task automatic report(string msg);
        $display("tb: mismatch %s", msg);
        mismatches++;
    endtask

    assign fail_count    = mismatches;
    assign pending_count = noise_queue.size();

    // predict on request, compare on result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                noise_queue.push_back(fbm_noise(s_x_coord, s_y_coord, s_seed, s_octave_count));
            if (m_valid && m_ready) begin
                if (noise_queue.size() == 0)
                    report($sformatf("unexpected result %0d", m_noise_value));
                else begin
                    logic [FB:0] want;
                    want = noise_queue.pop_front();
                    if (want !== m_noise_value)
                        report($sformatf("noise_value got %0d want %0d", m_noise_value, want));
                end
            end
        end
    end
endmodule

>>> tb/sv/fractal_value_noise_2d_core_test.sv
module fractal_value_noise_2d_core_test;
    localparam int RAND_REQUESTS = 1950;
    localparam int STALL_LIMIT   = 20000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_x_coord = 0;
    logic signed [31:0] s_y_coord = 0;
    logic [31:0]        s_seed = 0;
    logic [3:0]         s_octave_count = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [16:0]        m_noise_value;
    int                 fail_count, pending_count;
    int                 idle_cycles = 0;
    bit                 busy_phase = 0;
    bit                 done = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    fractal_value_noise_2d_core dut (.*);

    fvn_checker chk (.*);

    // random result backpressure, none during the busy stretch
    always @(posedge aclk)
        m_ready <= busy_phase ? 1'b1 : ($urandom_range(99) >= 32);

    // watchdog on accepted handshakes
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !done) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(logic [31:0] x, logic [31:0] y, logic [31:0] seed,
                                logic [3:0] cnt);
        while (!busy_phase && $urandom_range(99) < 32) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid        <= 1;
        s_x_coord      <= x;
        s_y_coord      <= y;
        s_seed         <= seed;
        s_octave_count <= cnt;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    initial begin
        logic [31:0] rx, ry;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // corner values of fields, every octave count up to the maximum and counts above it
        send_request(32'h8000_0000, 32'h8000_0000, 32'h0, 4'd1);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd8);
        send_request(32'h0, 32'h0, 32'h0, 4'd0);
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 4'd0);
        send_request(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hA5A5_A5A5, 4'd15);
        send_request(32'h0001_0000, 32'hFFFF_0000, 32'h5A5A_5A5A, 4'd9);
        for (int c = 1; c <= 8; c++)
            send_request($urandom, $urandom, $urandom, c[3:0]);
        send_request(32'h0000_8000, 32'h0000_8000, 32'd7, 4'd3);
        send_request(32'h7FFF_8000, 32'h8000_7FFF, 32'd1, 4'd8);
        for (int i = 0; i < RAND_REQUESTS; i++) begin
            busy_phase = (i >= 800 && i < 1000);
            rx = $urandom;
            ry = $urandom;
            if ($urandom_range(3) == 0) begin
                rx = $signed(rx) >>> $urandom_range(31);
                ry = $signed(ry) >>> $urandom_range(31);
            end
            send_request(rx, ry, $urandom,
                         ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8)));
        end
        s_valid <= 0;
        busy_phase = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        done = 1;
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
